>>> src/assert_macros.svh
// assertion macros shared by the rtl files
// clocked on clk; SSCD_ASSERT is disabled while arst_n is low, SSCD_ASSERT_ALWAYS is not
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SSCD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define SSCD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SSCD_ASSERT(label, prop, msg)
`define SSCD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

>>> src/sscd_pkg.sv
package sscd_pkg;

	localparam int unsigned COUNT_W  = 7;
	localparam int unsigned MS_W     = 16;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned SEG_W    = 7;

	localparam logic [COUNT_W-1:0] COUNT_MAX   = 7'd99;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd20;
	localparam logic [MS_W-1:0]    MS_MAX      = 16'hFFFF;

	localparam logic [MS_W-1:0] SECOND_PERIOD_RESET = 16'd1000;
	localparam logic [MS_W-1:0] IDLE_TIMEOUT_RESET  = 16'd250;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_PERIOD = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT  = 8'd1;

	// item kinds
	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// character codes
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;

	typedef struct packed {
		logic       action;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [SEG_W-1:0]   left_segments;
		logic [SEG_W-1:0]   right_segments;
		logic [COUNT_W-1:0] count_now;
		logic               display_updated;
	} result_t;

	typedef struct packed {
		logic [MS_W-1:0] second_period_ms;
		logic [MS_W-1:0] idle_timeout_ms;
	} cfg_regs_t;

endpackage

>>> src/sscd_ifs.sv
interface sscd_item_if;
	import sscd_pkg::*;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] rx_byte;
	modport source (output valid, output action, output rx_byte, input ready);
	modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface sscd_result_if;
	import sscd_pkg::*;
	logic               valid;
	logic               ready;
	logic [SEG_W-1:0]   left_segments;
	logic [SEG_W-1:0]   right_segments;
	logic [COUNT_W-1:0] count_now;
	logic               display_updated;
	modport source (output valid, output left_segments, output right_segments,
		output count_now, output display_updated, input ready);
	modport sink   (input valid, input left_segments, input right_segments,
		input count_now, input display_updated, output ready);
endinterface

interface sscd_cfg_if;
	import sscd_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [MS_W-1:0]      data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/serial_set_countdown_seven_segment.sv
// channel | dir | payload                                            | accepted
// cmd     | in  | action, rx_byte                                    | valid && ready
// disp    | out | left_segments, right_segments, count_now,          | valid && ready
//         |     | display_updated                                    |
// cfg     | in  | index, data (write only, always ready)             | valid && ready
//
// one item per cycle sustained while disp.ready keeps up; an item is taken into the input register,
// then its result shows when the result register loads from it; the state update is a single pass
// reset: count 20, phases and pending value 0, period 1000, idle timeout 250
// a stalled result holds in its register while one more item waits in the input
// register; cmd.ready drops only when both are full and disp.ready is low
`include "assert_macros.svh"

module serial_set_countdown_seven_segment (
	input  logic          clk,
	input  logic          arst_n,
	sscd_item_if.sink     cmd,
	sscd_result_if.source disp,
	sscd_cfg_if.sink      cfg
);
	import sscd_pkg::*;

	// configuration registers
	cfg_regs_t regs_q;

	// input register
	item_t item_s1;
	logic  valid_s1;

	// result register
	result_t res_q;
	logic    out_valid_q;

	logic               advance;
	logic               take;
	logic               core_en;
	logic [COUNT_W-1:0] count_next;
	logic               updated_next;
	logic [SEG_W-1:0]   left_next;
	logic [SEG_W-1:0]   right_next;

	// result register frees when empty or taken this cycle
	assign advance   = !out_valid_q || disp.ready;
	assign cmd.ready = !valid_s1 || advance;
	assign take      = cmd.valid && cmd.ready;
	assign core_en   = valid_s1 && advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.second_period_ms <= SECOND_PERIOD_RESET;
			regs_q.idle_timeout_ms  <= IDLE_TIMEOUT_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SECOND_PERIOD: regs_q.second_period_ms <= cfg.data;
				REG_IDLE_TIMEOUT:  regs_q.idle_timeout_ms  <= cfg.data;
				default: ;  // unknown index dropped
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.action  <= cmd.action;
			item_s1.rx_byte <= cmd.rx_byte;
		end
	end

	// timer state and per-item update
	sscd_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (core_en),
		.item         (item_s1),
		.regs         (regs_q),
		.count_next   (count_next),
		.updated_next (updated_next)
	);

	// digit patterns of the new count
	sscd_seg u_seg (
		.count          (count_next),
		.left_segments  (left_next),
		.right_segments (right_next)
	);

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (core_en) begin
			res_q.left_segments   <= left_next;
			res_q.right_segments  <= right_next;
			res_q.count_now       <= count_next;
			res_q.display_updated <= updated_next;
		end
	end

	assign disp.valid           = out_valid_q;
	assign disp.left_segments   = res_q.left_segments;
	assign disp.right_segments  = res_q.right_segments;
	assign disp.count_now       = res_q.count_now;
	assign disp.display_updated = res_q.display_updated;

	`SSCD_ASSERT(a_ready_only_full, !cmd.ready |-> (valid_s1 && out_valid_q && !disp.ready), "input stalled without full pipe")
	`SSCD_ASSERT(a_s1_held, (valid_s1 && !advance) |=> valid_s1, "waiting item dropped")
	`SSCD_ASSERT(a_result_follows, core_en |=> out_valid_q, "processed item gave no result")

endmodule

>>> src/sscd_seg.sv
module sscd_seg (
	input  logic [sscd_pkg::COUNT_W-1:0] count,
	output logic [sscd_pkg::SEG_W-1:0]   left_segments,
	output logic [sscd_pkg::SEG_W-1:0]   right_segments
);
	import sscd_pkg::*;

	localparam logic [SEG_W-1:0] SEG_TABLE [10] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
	};

	logic [COUNT_W-1:0] clamped;
	logic [14:0]        scaled;
	logic [3:0]         tens;
	logic [COUNT_W-1:0] tens_x10;
	logic [3:0]         ones;

	// tens digit by reciprocal multiply, exact for 0..99
	always_comb begin
		clamped  = (count > COUNT_MAX) ? COUNT_MAX : count;
		scaled   = 15'(clamped) * 15'd205;
		tens     = scaled[14:11];
		tens_x10 = COUNT_W'({tens, 3'b000}) + COUNT_W'({tens, 1'b0});
		ones     = 4'(clamped - tens_x10);
		left_segments  = SEG_TABLE[tens];
		right_segments = SEG_TABLE[ones];
	end

endmodule

>>> src/sscd_core.sv
`include "assert_macros.svh"

module sscd_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  sscd_pkg::item_t              item,
	input  sscd_pkg::cfg_regs_t          regs,
	output logic [sscd_pkg::COUNT_W-1:0] count_next,
	output logic                         updated_next
);
	import sscd_pkg::*;

	logic [COUNT_W-1:0] count_q, count_n;
	logic [MS_W-1:0]    phase_q, phase_n;
	logic [MS_W-1:0]    idle_q, idle_n;
	logic [COUNT_W-1:0] pend_q, pend_n;

	logic               commit;
	logic               upd;
	logic [9:0]         digit_val;
	logic [COUNT_W:0]   sum;
	logic [MS_W-1:0]    phase_inc;

	always_comb begin
		idle_n    = idle_q;
		pend_n    = pend_q;
		count_n   = count_q;
		phase_n   = phase_q;
		commit    = 1'b0;
		upd       = 1'b0;
		digit_val = {pend_q, 3'b000} + {2'b00, pend_q, 1'b0} + {6'd0, item.rx_byte[3:0]};
		sum       = {1'b0, count_q} + {1'b0, pend_q};
		phase_inc = (phase_q == MS_MAX) ? phase_q : phase_q + 1'b1;

		if (item.action == ACT_BYTE) begin
			idle_n = '0;
			if (item.rx_byte == CH_LF || item.rx_byte == CH_CR) begin
				commit = 1'b1;
			end else if (item.rx_byte >= CH_ZERO && item.rx_byte <= CH_NINE) begin
				pend_n = (digit_val > 10'(COUNT_MAX)) ? COUNT_MAX : digit_val[COUNT_W-1:0];
			end
		end else begin
			idle_n = (idle_q == MS_MAX) ? idle_q : idle_q + 1'b1;
			commit = idle_n > regs.idle_timeout_ms;
		end

		// commit adds the pending value, saturating
		if (commit) begin
			pend_n = '0;
			if (pend_q != '0) begin
				count_n = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_W-1:0];
				upd     = 1'b1;
			end
		end

		// second phase, held at the period while the count sits at zero
		if (item.action == ACT_TICK) begin
			phase_n = phase_inc;
			if (count_n != '0) begin
				if (phase_inc >= regs.second_period_ms) begin
					phase_n = phase_inc - regs.second_period_ms;
					count_n = count_n - 1'b1;
					upd     = 1'b1;
				end
			end else if (phase_inc > regs.second_period_ms) begin
				phase_n = regs.second_period_ms;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
			phase_q <= '0;
			idle_q  <= '0;
			pend_q  <= '0;
		end else if (en) begin
			count_q <= count_n;
			phase_q <= phase_n;
			idle_q  <= idle_n;
			pend_q  <= pend_n;
		end
	end

	assign count_next   = count_n;
	assign updated_next = upd;

	`SSCD_ASSERT(a_count_range, count_q <= COUNT_MAX, "count above 99")
	`SSCD_ASSERT(a_pend_range, pend_q <= COUNT_MAX, "pending value above 99")
	`SSCD_ASSERT(a_state_hold, !en |=> ($stable(count_q) && $stable(pend_q)), "state moved without item")

endmodule
